@@ src/kdf_pkg.sv @@
// ----------------------------------------------------------------------------
// kdf_pkg: shared definitions for the keyed duplicate filter
// Table size, derived widths, the sequencer state type and the write port
// bundle between the sequencer and the key store.
// ----------------------------------------------------------------------------
package kdf_pkg;

    // Number of keys the table can hold in one list.
    localparam int TABLE_DEPTH = 32;

    // Key is 20 bytes: 8 + 8 + 4.
    localparam int KEY_LO_W  = 64;
    localparam int KEY_MID_W = 64;
    localparam int KEY_HI_W  = 32;
    localparam int KEY_W     = KEY_LO_W + KEY_MID_W + KEY_HI_W;

    // Index into the table, and a count that can also hold TABLE_DEPTH.
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Width of the reported slot field.
    localparam int SLOT_W = 5;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Write port of the key store.
    typedef struct packed {
        logic en;
        idx_t addr;
        key_t data;
    } kdf_wr_t;

endpackage

@@ src/kdf_key_store.sv @@
// ----------------------------------------------------------------------------
// kdf_key_store: key table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kdf_key_store (
    input  logic            clk,
    input  kdf_pkg::kdf_wr_t wr,
    input  logic            rd_en,
    input  kdf_pkg::idx_t   rd_addr,
    output kdf_pkg::key_t   rd_data
);

    kdf_pkg::key_t mem [kdf_pkg::TABLE_DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read port, data valid the cycle after the address.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/keyed_duplicate_filter_top.sv @@
// ----------------------------------------------------------------------------
// keyed_duplicate_filter_top: keep-first duplicate filter on 20-byte keys
// Scans the stored keys of the current list one per cycle and reports each
// incoming key as kept, dropped (repeat) or overflowed (table full).
// ----------------------------------------------------------------------------
// Usage:
// Input beats carry one key in three fields plus last_of_list; output beats
// carry kept, slot and overflow, exactly one per input beat, in order.
// An input beat is taken only while the block is idle. The key is then
// compared with the n keys stored so far, one stored key per cycle through
// the single read port of the key table; the scan ends early on a match and
// is followed by a step that decides and stores. The next input beat can be
// taken the cycle after the result is loaded, so a new key is never taken
// before the last one is finished.
// The result sits in an output register; while the receiver stalls, the
// block holds its decision and takes no new input beat. The table keeps only
// as many keys as the list count says, so it needs no clearing pass.
// Reset empties the list and drops any pending result. A beat marked last
// ends the list: after its result is formed the list count returns to zero.
// ----------------------------------------------------------------------------
module keyed_duplicate_filter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] key_bytes_0_to_7,
    input  logic [63:0] key_bytes_8_to_15,
    input  logic [31:0] key_bytes_16_to_19,
    input  logic        last_of_list,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kept,
    output logic [4:0]  slot,
    output logic        overflow
);

    kdf_pkg::state_t state_reg, state_next;
    kdf_pkg::key_t   key_reg;
    logic            last_reg;
    kdf_pkg::cnt_t   count_reg, count_next;
    kdf_pkg::cnt_t   rd_idx_reg;
    kdf_pkg::cnt_t   cmp_idx_reg;
    logic            cmp_valid_reg;
    logic            found_reg;
    kdf_pkg::cnt_t   where_reg;
    logic            out_valid_reg;
    logic            kept_reg, kept_next;
    logic [kdf_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic            overflow_reg, overflow_next;

    logic            in_fire;
    logic            issue;
    logic            hit;
    logic            load;
    logic            has_room;
    kdf_pkg::kdf_wr_t wr;
    kdf_pkg::key_t   rd_data;

    assign in_fire  = in_valid && in_ready;
    assign hit      = cmp_valid_reg && (rd_data == key_reg);
    assign has_room = (count_reg < kdf_pkg::CNT_W'(kdf_pkg::TABLE_DEPTH));

    // Key table.
    kdf_key_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (issue),
        .rd_addr (rd_idx_reg[kdf_pkg::IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kdf_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = kdf_pkg::ST_SCAN;
                end
            end
            kdf_pkg::ST_SCAN:
            begin
                if (hit || !issue)
                begin
                    state_next = kdf_pkg::ST_DONE;
                end
            end
            kdf_pkg::ST_DONE:
            begin
                if (load)
                begin
                    state_next = kdf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kdf_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        in_ready = 1'b0;
        issue    = 1'b0;
        load     = 1'b0;
        case (state_reg)
            kdf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            kdf_pkg::ST_SCAN:
            begin
                issue = (rd_idx_reg < count_reg) && !hit;
            end
            kdf_pkg::ST_DONE:
            begin
                load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Decision: repeat, new key stored, or table full.
    always_comb
    begin
        kept_next     = 1'b0;
        slot_next     = '0;
        overflow_next = 1'b0;
        count_next    = count_reg;
        wr.en         = 1'b0;
        wr.addr       = count_reg[kdf_pkg::IDX_W-1:0];
        wr.data       = key_reg;
        if (found_reg)
        begin
            slot_next = where_reg[kdf_pkg::SLOT_W-1:0];
        end
        else if (has_room)
        begin
            kept_next  = 1'b1;
            slot_next  = count_reg[kdf_pkg::SLOT_W-1:0];
            count_next = count_reg + 1'b1;
            wr.en      = load;
        end
        else
        begin
            overflow_next = 1'b1;
        end
        if (last_reg)
        begin
            count_next = '0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kdf_pkg::ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= issue;
            if (load)
            begin
                count_reg <= count_next;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and scan registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            key_reg    <= {key_bytes_16_to_19, key_bytes_8_to_15, key_bytes_0_to_7};
            last_reg   <= last_of_list;
            rd_idx_reg <= '0;
            found_reg  <= 1'b0;
            where_reg  <= '0;
        end
        else if (state_reg == kdf_pkg::ST_SCAN)
        begin
            if (issue)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (hit)
            begin
                found_reg <= 1'b1;
                where_reg <= cmp_idx_reg;
            end
        end
        cmp_idx_reg <= rd_idx_reg;
        if (load)
        begin
            kept_reg     <= kept_next;
            slot_reg     <= slot_next;
            overflow_reg <= overflow_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign kept      = kept_reg;
    assign slot      = slot_reg;
    assign overflow  = overflow_reg;

    // The list never holds more keys than the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= kdf_pkg::CNT_W'(kdf_pkg::TABLE_DEPTH))
        else $error("list count exceeds table depth");

    // A key is written only when it matched nothing and there is room.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (!found_reg && has_room && state_reg == kdf_pkg::ST_DONE))
        else $error("table written for a repeated key or a full table");

    // Finishing a last beat empties the list.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && last_reg) |=> (count_reg == '0))
        else $error("list not emptied after last beat");

    // A new scan starts at the first slot with no compare pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == kdf_pkg::ST_SCAN && rd_idx_reg == '0
                     && !cmp_valid_reg && !found_reg))
        else $error("scan did not start clean");

endmodule

@@ verif/keyed_duplicate_filter_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_duplicate_filter_top_tb: self-checking bench for the duplicate filter
// Feeds lists of 20-byte keys and checks each output beat against an
// in-bench model of the keep-first table. The directed part covers the
// extremes, repeats, padding after the terminator, a full table and the end
// of a list. Random lists follow under four idling phases and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module keyed_duplicate_filter_top_tb;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int ITEMS_PER_PHASE = 320;
    localparam int N_ROWS         = 19;

    // One output beat.
    typedef struct packed {
        logic                       kept;
        logic [kdf_pkg::SLOT_W-1:0] slot;
        logic                       overflow;
    } result_t;

    // One row of the directed table; reps > 1 sends keys key, key+1, ...
    typedef struct packed {
        kdf_pkg::key_t key;
        logic    last;
        logic [5:0] reps;
        logic    typed;
        result_t want;
    } row_t;

    localparam kdf_pkg::key_t ONES  = {160{1'b1}};
    localparam kdf_pkg::key_t K_A   = 160'h41;
    localparam kdf_pkg::key_t K_PAD = 160'h0000_4200_0000_0041;
    localparam kdf_pkg::key_t K_MID = {32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0};
    localparam kdf_pkg::key_t K_HI  = {32'hFFFF_FFFF, 64'h0, 64'h0};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] key_bytes_0_to_7;
    logic [63:0] key_bytes_8_to_15;
    logic [31:0] key_bytes_16_to_19;
    logic        last_of_list;
    logic        out_valid;
    logic        out_ready;
    logic        kept;
    logic [4:0]  slot;
    logic        overflow;

    // Typed expectation that travels with the beat on offer.
    logic    pend_typed;
    result_t pend_want;

    int      idle_pct;
    int      stall_pct = 0;
    int      hold_req = 0;
    int      mismatches = 0;
    int      idle_cycles = 0;

    kdf_pkg::key_t stored_keys [kdf_pkg::TABLE_DEPTH];
    int      stored_count = 0;
    result_t expected_results [$];

    row_t directed_rows [0:N_ROWS-1] = '{
        '{160'h0,       1'b0, 6'd1,  1'b1, '{1'b1, 5'd0,  1'b0}},
        '{ONES,         1'b0, 6'd1,  1'b1, '{1'b1, 5'd1,  1'b0}},
        '{160'h0,       1'b0, 6'd1,  1'b1, '{1'b0, 5'd0,  1'b0}},
        '{ONES,         1'b0, 6'd1,  1'b1, '{1'b0, 5'd1,  1'b0}},
        '{K_PAD,        1'b0, 6'd1,  1'b1, '{1'b1, 5'd2,  1'b0}},
        '{K_A,          1'b0, 6'd1,  1'b1, '{1'b1, 5'd3,  1'b0}},
        '{K_MID,        1'b0, 6'd1,  1'b1, '{1'b1, 5'd4,  1'b0}},
        '{K_HI,         1'b0, 6'd1,  1'b1, '{1'b1, 5'd5,  1'b0}},
        '{160'h1000,    1'b0, 6'd26, 1'b0, '{1'b0, 5'd0,  1'b0}},
        '{160'hBEEF,    1'b0, 6'd1,  1'b1, '{1'b0, 5'd0,  1'b1}},
        '{K_A,          1'b0, 6'd1,  1'b1, '{1'b0, 5'd3,  1'b0}},
        '{160'h1019,    1'b0, 6'd1,  1'b1, '{1'b0, 5'd31, 1'b0}},
        '{160'h0,       1'b1, 6'd1,  1'b1, '{1'b0, 5'd0,  1'b0}},
        '{ONES,         1'b1, 6'd1,  1'b1, '{1'b1, 5'd0,  1'b0}},
        '{ONES,         1'b0, 6'd1,  1'b1, '{1'b1, 5'd0,  1'b0}},
        '{160'h2000,    1'b0, 6'd31, 1'b0, '{1'b0, 5'd0,  1'b0}},
        '{160'h3000,    1'b1, 6'd1,  1'b1, '{1'b0, 5'd0,  1'b1}},
        '{160'h2000,    1'b0, 6'd1,  1'b1, '{1'b1, 5'd0,  1'b0}},
        '{160'h2000,    1'b1, 6'd1,  1'b1, '{1'b0, 5'd0,  1'b0}}
    };

    keyed_duplicate_filter_top uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .key_bytes_0_to_7   (key_bytes_0_to_7),
        .key_bytes_8_to_15  (key_bytes_8_to_15),
        .key_bytes_16_to_19 (key_bytes_16_to_19),
        .last_of_list       (last_of_list),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .kept               (kept),
        .slot               (slot),
        .overflow           (overflow)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Keep-first table model: match the lowest stored slot, else store.
    function automatic result_t classify_key(kdf_pkg::key_t k, logic last);
        result_t r;
        int      hit;
        r   = '0;
        hit = -1;
        for (int j = 0; j < stored_count; j++)
        begin
            if (hit < 0 && stored_keys[j] == k)
                hit = j;
        end
        if (hit >= 0)
            r.slot = kdf_pkg::SLOT_W'(hit);
        else if (stored_count < kdf_pkg::TABLE_DEPTH)
        begin
            stored_keys[stored_count] = k;
            r.kept = 1'b1;
            r.slot = kdf_pkg::SLOT_W'(stored_count);
            stored_count++;
        end
        else
            r.overflow = 1'b1;
        if (last)
            stored_count = 0;
        return r;
    endfunction

    // Name-like key: nonzero bytes up to a terminator, zero after it;
    // now and then a fully random key so every bit toggles.
    function automatic kdf_pkg::key_t random_key();
        kdf_pkg::key_t k;
        int   n;
        k = '0;
        if ($urandom_range(9) < 2)
            k = {$urandom, $urandom, $urandom, $urandom, $urandom};
        else
        begin
            n = $urandom_range(1, 20);
            for (int b = 0; b < n; b++)
                k[8*b +: 8] = 8'($urandom_range(1, 255));
        end
        return k;
    endfunction

    // Offer one input beat, with random idle cycles ahead of it, and hold it
    // until it is accepted.
    task automatic send_item(kdf_pkg::key_t k, logic last, logic typed, result_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid           <= 1'b1;
        key_bytes_0_to_7   <= k[63:0];
        key_bytes_8_to_15  <= k[127:64];
        key_bytes_16_to_19 <= k[159:128];
        last_of_list       <= last;
        pend_typed         <= typed;
        pend_want          <= want;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Random lists: mostly well-formed lists with repeats drawn from the
    // keys already sent in the list, some long enough to overflow, and a few
    // stray last marks.
    task automatic send_random_lists(int n_items);
        kdf_pkg::key_t keys_in_list [$];
        kdf_pkg::key_t k;
        int   sent;
        int   len;
        int   repeat_pct;
        logic last;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(9))
                0:       len = $urandom_range(33, 50);
                1, 2:    len = $urandom_range(30, 34);
                default: len = $urandom_range(1, 29);
            endcase
            repeat_pct = $urandom_range(0, 60);
            keys_in_list.delete();
            for (int j = 0; j < len; j++)
            begin
                if (keys_in_list.size() != 0 && $urandom_range(99) < repeat_pct)
                    k = keys_in_list[$urandom_range(keys_in_list.size() - 1)];
                else
                begin
                    k = random_key();
                    keys_in_list.push_back(k);
                end
                last = (j == len - 1) || ($urandom_range(99) < 2);
                send_item(k, last, 1'b0, '0);
                if (last)
                    keys_in_list.delete();
                sent++;
            end
        end
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial
    begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Input monitor: every accepted beat gets an expectation.
    always @(posedge clk)
    begin
        result_t r;
        if (rst_n && in_valid && in_ready)
        begin
            r = classify_key({key_bytes_16_to_19, key_bytes_8_to_15, key_bytes_0_to_7},
                             last_of_list);
            if (pend_typed)
                r = pend_want;
            expected_results.push_back(r);
        end
    end

    // Output monitor: compare each beat with the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected beat: expected none, got kept %0d slot %0d overflow %0d",
                         $time, kept, slot, overflow);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (kept !== want.kept)
                begin
                    $display("%0t: kept mismatch: expected %0d, got %0d",
                             $time, want.kept, kept);
                    mismatches++;
                end
                if (slot !== want.slot)
                begin
                    $display("%0t: slot mismatch: expected %0d, got %0d",
                             $time, want.slot, slot);
                    mismatches++;
                end
                if (overflow !== want.overflow)
                begin
                    $display("%0t: overflow mismatch: expected %0d, got %0d",
                             $time, want.overflow, overflow);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("[keyed_duplicate_filter_top] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Main sequence.
    initial
    begin
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        key_bytes_0_to_7   = '0;
        key_bytes_8_to_15  = '0;
        key_bytes_16_to_19 = '0;
        last_of_list       = 1'b0;
        pend_typed         = 1'b0;
        pend_want          = '0;
        idle_pct           = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table with light idling on both sides.
        idle_pct  = 9;
        stall_pct <= 9;
        for (int r = 0; r < N_ROWS; r++)
        begin
            for (int i = 0; i < directed_rows[r].reps; i++)
                send_item(directed_rows[r].key + kdf_pkg::key_t'(i), directed_rows[r].last,
                          directed_rows[r].typed, directed_rows[r].want);
        end

        // Random lists under each idling phase; the first phase starts with a
        // long receiver hold-off so the block backs up into the input.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct <= 0;
                    hold_req  <= hold_req + 1;
                end
                1:
                begin
                    idle_pct  = 66;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct <= 66;
                end
                default:
                begin
                    idle_pct  = 9;
                    stall_pct <= 9;
                end
            endcase
            send_random_lists(ITEMS_PER_PHASE);
        end
        in_valid <= 1'b0;

        // Drain, then allow for any stray beat.
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[keyed_duplicate_filter_top] OK");
        else
            $display("[keyed_duplicate_filter_top] ERROR");
        $finish;
    end

endmodule
